// File: rtl/pidawd_pkg.sv
package pidawd_pkg;

  // Shared multiplier operand and product widths.
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // Divider widths: signed dividend, unsigned divisor.
  localparam int DIV_NW = 64;
  localparam int DIV_DW = 33;

  // Fixed tuning constants of the controller.
  localparam logic [31:0] OVERSHOOT_ERR   = 32'd0;
  localparam logic [31:0] DOMINANCE_RATIO = 32'd32768;
  localparam logic [16:0] LEAK_FRACTION   = 17'd0;
  localparam logic [30:0] DERIV_TAU       = 31'd0;
  localparam logic [31:0] DERIV_DEADBAND  = 32'd0;
  localparam logic [16:0] BLEND_GAIN      = 17'd19661;
  localparam logic [16:0] LEAK_KEEP       = 17'd65536 - LEAK_FRACTION;

  // Configuration register indexes.
  localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [2:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [2:0] REG_DRIVE_MAX   = 3'd3;
  localparam logic [2:0] REG_DRIVE_MIN   = 3'd4;
  localparam logic [2:0] REG_INTEG_CLAMP = 3'd5;
  localparam logic [2:0] REG_DERIV_CLAMP = 3'd6;
  localparam logic [2:0] REG_MODE_FLAGS  = 3'd7;

  // Saturation handling modes of the derivative term.
  localparam logic [1:0] SAT_CUT   = 2'd1;
  localparam logic [1:0] SAT_BLEND = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_ERR, S_ERRDT, S_FP, S_FI, S_FD, S_DOM, S_LEAK, S_INTEG, S_CI,
    S_DSIG, S_DIV1, S_TAU1, S_TAU2, S_DIV2, S_SMODE, S_BLEND, S_DUPD, S_CD,
    S_OUT
  } pidawd_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
    if (v > 66'sh7FFF_FFFF_FFFF) begin
      return 48'sh7FFF_FFFF_FFFF;
    end else if (v < -66'sh8000_0000_0000) begin
      return 48'sh8000_0000_0000;
    end
    return v[47:0];
  endfunction

  function automatic logic signed [65:0] clamp_sym(input logic signed [65:0] v,
                                                   input logic [30:0] lim);
    logic signed [65:0] l;
    l = $signed({35'd0, lim});
    if (v > l) begin
      return l;
    end else if (v < -l) begin
      return -l;
    end
    return v;
  endfunction

endpackage

// File: rtl/pidawd_if.sv
interface pidawd_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] reference;
  logic signed [31:0] measured;
  logic        [30:0] step_time;
  modport source(output valid, reference, measured, step_time, input ready);
  modport sink(input valid, reference, measured, step_time, output ready);
endinterface

interface pidawd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive;
  logic               saturated;
  modport source(output valid, drive, saturated, input ready);
  modport sink(input valid, drive, saturated, output ready);
endinterface

interface pidawd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/pid_antiwindup_filtered_derivative_unit.sv
// PID controller with conditional anti-windup and a filtered derivative. Each
// input word carries a reference and a measurement in signed Q16.16 and an
// unsigned Q15.16 step time; each output word returns the drive clamped to
// drive_min..drive_max and a flag that is set when the unclamped sum lay
// outside those limits. One word is processed at a time: the input is
// ready only while the sequencer is idle. All gain products run through one
// shared 33x33 multiplier, each Q16.16 product as two partial products, and
// the derivative quotient runs through a 64-step restoring divider. A
// nonzero low-pass time constant adds a second division and two plain
// products. The divider's iterations dominate the time of a sample with the
// derivative path active. A stalled output word holds the sequencer until it
// is taken.
// Configuration registers may be written at any time the block is idle and
// take effect on the next word.
module pid_antiwindup_filtered_derivative_unit (
  input logic          clk,
  input logic          rst,
  pidawd_in_if.sink    in_ch,
  pidawd_out_if.source out_ch,
  pidawd_cfg_if.sink   cfg
);
  import pidawd_pkg::*;

  // Configuration registers.
  logic signed [31:0] prop_gain, integ_gain, deriv_gain, drive_max, drive_min;
  logic        [30:0] integ_clamp, deriv_clamp;
  logic        [3:0]  mode_flags;

  // Controller state kept between samples.
  logic signed [47:0] integ_acc;
  logic signed [31:0] last_error, last_sig, last_filt;
  logic               last_error_valid, last_sig_valid;

  // Per-sample working registers.
  logic signed [31:0] ref_r, meas_r, err, fp, fi, fd, ci, cd, sig_r, raw, filt, d_r;
  logic        [30:0] dt_r;
  logic signed [47:0] fut, leakv;
  logic signed [63:0] tacc;
  logic               hinder, dead_r;

  // Output register.
  logic               out_valid;
  logic signed [31:0] drive_r;
  logic               sat_r;

  pidawd_state_t st, st_next;
  logic [1:0]    ph, ph_next;

  // Shared multiplier and divider.
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod, hold, mq_res;
  logic signed [MUL_W-1:0]  mq_a;
  logic signed [48:0]       mq_b;
  logic                     div_start, div_done;
  logic signed [DIV_NW-1:0] div_num, quo;
  logic        [DIV_DW-1:0] div_den;

  // Combinational helpers.
  logic               mq_last;
  logic signed [32:0] fp_abs, fi_abs, err_abs, delta, delta_abs, neg_meas;
  logic signed [31:0] sig, gd;
  logic signed [33:0] fu, gu, u;
  logic               flip, skip, use_leak, sat_hit;
  logic signed [47:0] acc_new;
  logic        [1:0]  smode;

  pidawd_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  pidawd_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(quo)
  );

  assign cfg.ready        = 1'b1;
  assign in_ch.ready      = (st == S_IDLE);
  assign out_ch.valid     = out_valid;
  assign out_ch.drive     = drive_r;
  assign out_ch.saturated = sat_r;

  // A Q16.16 product is the high partial product plus the low partial
  // product shifted down, which equals floor(a*b / 2^16) exactly.
  assign mq_res  = hold + (prod >>> 16);
  assign mq_last = (ph == 2'd2);
  assign smode   = mode_flags[3:2];

  always_comb begin
    fp_abs    = fp[31] ? -33'(fp) : 33'(fp);
    fi_abs    = fi[31] ? -33'(fi) : 33'(fi);
    err_abs   = err[31] ? -33'(err) : 33'(err);
    neg_meas  = -33'(meas_r);
    sig       = mode_flags[1] ? sat32(66'(neg_meas)) : err;
    delta     = 33'(sig) - 33'(last_sig);
    delta_abs = delta[32] ? -delta : delta;
    gd        = sat32(mq_res);
    fu        = 34'(fp) + 34'(fi) + 34'(fd);
    gu        = 34'(fp) + 34'(ci) + 34'(gd);
    u         = 34'(fp) + 34'(ci) + 34'(cd);
    flip      = (last_error < 0 && err > 0) || (last_error > 0 && err < 0);
    sat_hit   = (gu > 34'(drive_max) && gd > 0) || (gu < 34'(drive_min) && gd < 0);

    // Anti-windup: hold the integral when the drive is pushed further into
    // saturation, or when it dominates right after an error sign change.
    skip     = mode_flags[0] &&
               (((fu > 34'(drive_max)) && err > 0) || ((fu < 34'(drive_min)) && err < 0) ||
                (hinder && LEAK_FRACTION == '0));
    use_leak = mode_flags[0] && hinder && LEAK_FRACTION != '0;
    acc_new  = skip ? integ_acc : (use_leak ? leakv : fut);
  end

  // Operand select for the Q16.16 products.
  always_comb begin
    mq_a = '0;
    mq_b = '0;
    case (st)
      S_ERRDT: begin
        mq_a = 33'(err);
        mq_b = $signed({18'd0, dt_r});
      end
      S_FP: begin
        mq_a = 33'(prop_gain);
        mq_b = 49'(err);
      end
      S_FI: begin
        mq_a = 33'(integ_gain);
        mq_b = 49'(fut);
      end
      S_FD: begin
        mq_a = 33'(deriv_gain);
        mq_b = 49'(last_filt);
      end
      S_DOM: begin
        mq_a = $signed({1'b0, DOMINANCE_RATIO});
        mq_b = 49'(fp_abs);
      end
      S_LEAK: begin
        mq_a = $signed({16'd0, LEAK_KEEP});
        mq_b = 49'(integ_acc);
      end
      S_CI: begin
        mq_a = 33'(integ_gain);
        mq_b = 49'(integ_acc);
      end
      S_SMODE: begin
        mq_a = 33'(deriv_gain);
        mq_b = 49'(filt);
      end
      S_BLEND: begin
        mq_a = $signed({16'd0, BLEND_GAIN});
        mq_b = 49'(filt);
      end
      S_CD: begin
        mq_a = 33'(deriv_gain);
        mq_b = 49'(d_r);
      end
      default: begin
        mq_a = '0;
        mq_b = '0;
      end
    endcase
  end

  // Multiplier feed; the low-pass terms use plain full-width products.
  always_comb begin
    case (st)
      S_TAU1: begin
        mul_a = $signed({2'b0, DERIV_TAU});
        mul_b = 33'(last_filt);
      end
      S_TAU2: begin
        mul_a = $signed({2'b0, dt_r});
        mul_b = 33'(raw);
      end
      default: begin
        mul_a = mq_a;
        mul_b = (ph == 2'd0) ? $signed(mq_b[48:16]) : $signed({17'd0, mq_b[15:0]});
      end
    endcase
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      ph <= 2'd0;
    end else begin
      st <= st_next;
      ph <= ph_next;
    end
  end

  // Next state, phase and divider control.
  always_comb begin
    st_next   = st;
    ph_next   = 2'd0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (st)
      S_IDLE: begin
        if (in_ch.valid) begin
          st_next = S_ERR;
        end
      end
      S_ERR: st_next = S_ERRDT;
      S_ERRDT, S_FP, S_FI, S_FD, S_DOM, S_LEAK, S_BLEND, S_CD: begin
        if (mq_last) begin
          case (st)
            S_ERRDT: st_next = S_FP;
            S_FP:    st_next = S_FI;
            S_FI:    st_next = S_FD;
            S_FD:    st_next = S_DOM;
            S_DOM:   st_next = S_LEAK;
            S_LEAK:  st_next = S_INTEG;
            S_BLEND: st_next = S_DUPD;
            default: st_next = S_OUT;
          endcase
        end else begin
          ph_next = ph + 2'd1;
        end
      end
      S_INTEG: st_next = S_CI;
      S_CI: begin
        if (mq_last) begin
          st_next = (deriv_gain != '0) ? S_DSIG : S_CD;
        end else begin
          ph_next = ph + 2'd1;
        end
      end
      S_DSIG: begin
        if (last_sig_valid) begin
          div_start = 1'b1;
          div_num   = 64'(delta) <<< 16;
          div_den   = {2'b0, dt_r};
          st_next   = S_DIV1;
        end else begin
          st_next = S_CD;
        end
      end
      S_DIV1: begin
        if (div_done) begin
          st_next = (DERIV_TAU != '0) ? S_TAU1 : S_SMODE;
        end
      end
      S_TAU1: begin
        if (ph == 2'd1) begin
          st_next = S_TAU2;
        end else begin
          ph_next = ph + 2'd1;
        end
      end
      S_TAU2: begin
        if (ph == 2'd1) begin
          div_start = 1'b1;
          div_num   = tacc + prod[63:0];
          div_den   = {2'b0, DERIV_TAU} + {2'b0, dt_r};
          st_next   = S_DIV2;
        end else begin
          ph_next = ph + 2'd1;
        end
      end
      S_DIV2: begin
        if (div_done) begin
          st_next = S_SMODE;
        end
      end
      S_SMODE: begin
        if (smode != SAT_CUT && smode != SAT_BLEND) begin
          st_next = S_DUPD;
        end else if (mq_last) begin
          st_next = (sat_hit && smode == SAT_BLEND) ? S_BLEND : S_DUPD;
        end else begin
          ph_next = ph + 2'd1;
        end
      end
      S_DUPD: st_next = S_CD;
      S_OUT: begin
        if (!out_valid || out_ch.ready) begin
          st_next = S_IDLE;
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= 32'sd65536;
      integ_gain  <= '0;
      deriv_gain  <= '0;
      drive_max   <= 32'sh7FFF_FFFF;
      drive_min   <= 32'sh8000_0000;
      integ_clamp <= '1;
      deriv_clamp <= '1;
      mode_flags  <= 4'd7;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PROP_GAIN:   prop_gain   <= cfg.data;
        REG_INTEG_GAIN:  integ_gain  <= cfg.data;
        REG_DERIV_GAIN:  deriv_gain  <= cfg.data;
        REG_DRIVE_MAX:   drive_max   <= cfg.data;
        REG_DRIVE_MIN:   drive_min   <= cfg.data;
        REG_INTEG_CLAMP: integ_clamp <= cfg.data[30:0];
        REG_DERIV_CLAMP: deriv_clamp <= cfg.data[30:0];
        REG_MODE_FLAGS:  mode_flags  <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

  // Controller state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      integ_acc        <= '0;
      last_error       <= '0;
      last_error_valid <= 1'b0;
      last_sig         <= '0;
      last_sig_valid   <= 1'b0;
      last_filt        <= '0;
      out_valid        <= 1'b0;
    end else begin
      // A new word may replace the one that is taken in the same cycle.
      if (st == S_OUT && (!out_valid || out_ch.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (st)
        S_INTEG: integ_acc <= 48'(clamp_sym(66'(acc_new), integ_clamp));
        S_DSIG: begin
          if (!last_sig_valid) begin
            last_sig       <= sig;
            last_sig_valid <= 1'b1;
            last_filt      <= '0;
          end
        end
        S_DUPD: begin
          last_sig  <= sig_r;
          last_filt <= filt;
        end
        S_OUT: begin
          if (!out_valid || out_ch.ready) begin
            last_error       <= err;
            last_error_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (ph == 2'd1) begin
      hold <= prod;
    end
    case (st)
      S_IDLE: begin
        ref_r  <= in_ch.reference;
        meas_r <= in_ch.measured;
        // A zero step time counts as one LSB.
        dt_r   <= (in_ch.step_time == '0) ? 31'd1 : in_ch.step_time;
        d_r    <= '0;
      end
      S_ERR: err <= sat32(66'(ref_r) - 66'(meas_r));
      S_ERRDT: if (mq_last) fut <= sat48(66'(integ_acc) + mq_res);
      S_FP: if (mq_last) fp <= gd;
      S_FI: if (mq_last) fi <= gd;
      S_FD: if (mq_last) fd <= (deriv_gain != '0) ? gd : '0;
      S_DOM: begin
        if (mq_last) begin
          hinder <= last_error_valid && flip && (err_abs > $signed({1'b0, OVERSHOOT_ERR})) &&
                    ((fp < 0 && fi > 0) || (fp > 0 && fi < 0)) &&
                    (66'(fi_abs) > mq_res);
        end
      end
      S_LEAK: if (mq_last) leakv <= mq_res[47:0];
      S_CI: if (mq_last) ci <= gd;
      S_DSIG: begin
        sig_r  <= sig;
        dead_r <= delta_abs < $signed({1'b0, DERIV_DEADBAND});
      end
      S_DIV1: begin
        if (div_done) begin
          raw  <= 32'(clamp_sym(dead_r ? 66'sd0 : 66'(quo), deriv_clamp));
          filt <= 32'(clamp_sym(dead_r ? 66'sd0 : 66'(quo), deriv_clamp));
        end
      end
      S_TAU1: if (ph == 2'd1) tacc <= prod[63:0];
      S_DIV2: if (div_done) filt <= 32'(clamp_sym(66'(quo), deriv_clamp));
      S_SMODE: if (mq_last && sat_hit && smode == SAT_CUT) filt <= '0;
      S_BLEND: if (mq_last) filt <= mq_res[31:0];
      S_DUPD: d_r <= filt;
      S_CD: if (mq_last) cd <= gd;
      S_OUT: begin
        if (!out_valid || out_ch.ready) begin
          if (u > 34'(drive_max)) begin
            drive_r <= drive_max;
            sat_r   <= 1'b1;
          end else if (u < 34'(drive_min)) begin
            drive_r <= drive_min;
            sat_r   <= 1'b1;
          end else begin
            drive_r <= u[31:0];
            sat_r   <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/pidawd_mul.sv
module pidawd_mul (
  input  logic                                  clk,
  input  logic signed [pidawd_pkg::MUL_W-1:0]   a,
  input  logic signed [pidawd_pkg::MUL_W-1:0]   b,
  output logic signed [pidawd_pkg::PROD_W-1:0]  prod
);
  import pidawd_pkg::*;

  // Product is registered; it is valid in the cycle after the operands.
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// File: rtl/pidawd_div.sv
module pidawd_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [pidawd_pkg::DIV_NW-1:0] num,
  input  logic        [pidawd_pkg::DIV_DW-1:0] den,
  output logic                                 done,
  output logic signed [pidawd_pkg::DIV_NW-1:0] quo
);
  import pidawd_pkg::*;

  localparam int CW = $clog2(DIV_NW);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [DIV_NW-1:0] n;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] den_r;
  logic              neg;
  logic [DIV_DW:0]   rem_sh;
  logic              fits;

  // Restoring division on magnitudes, one quotient bit per cycle.
  always_comb begin
    rem_sh = {rem, n[DIV_NW-1]};
    fits   = rem_sh >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        n     <= num[DIV_NW-1] ? DIV_NW'(-num) : num;
        rem   <= '0;
        neg   <= num[DIV_NW-1];
        den_r <= den;
      end else if (busy) begin
        if (fits) begin
          rem <= DIV_DW'(rem_sh - {1'b0, den_r});
        end else begin
          rem <= rem_sh[DIV_DW-1:0];
        end
        n   <= {n[DIV_NW-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIV_NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient truncates toward zero.
  assign quo = neg ? -$signed(n) : $signed(n);

endmodule

// File: sim/tb_pid_antiwindup_filtered_derivative_unit.sv
`timescale 1ns / 1ps

module tb_pid_antiwindup_filtered_derivative_unit;
  import pidawd_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #10 clk = ~clk;

  pidawd_in_if  in_ch();
  pidawd_out_if out_ch();
  pidawd_cfg_if cfg();

  pid_antiwindup_filtered_derivative_unit u_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source),
    .cfg(cfg.sink)
  );

  // One expected output word: the clamped drive and the saturation flag.
  typedef struct {
    logic signed [31:0] drive;
    logic               saturated;
  } drive_word_t;

  drive_word_t expected_drives[$];

  // The predictor's copy of the control registers. Values are widened to 64 bits so that
  // the sums and products below can be written without intermediate overflow.
  longint p_gain, i_gain, d_gain, lim_hi, lim_lo, i_clamp, d_clamp;
  logic [3:0] mode;

  // The predictor's copy of the controller state.
  longint integ, last_err, prev_sig, prev_filt;
  bit     last_err_ok, prev_sig_ok;

  int  mismatches;
  int  words_sent;
  int  words_checked;
  int  saturated_seen;
  longint cycle_count = 0;

  // Stall controls used by the sender and the receiver.
  bit  idle_free;
  bit  hold_off;

  function automatic longint sat_limit(longint v, longint lim);
    if (v > lim) begin
      return lim;
    end
    if (v < -lim - 1) begin
      return -lim - 1;
    end
    return v;
  endfunction

  function automatic longint sat_word(longint v);
    return sat_limit(v, 64'sd2147483647);
  endfunction

  function automatic longint clamp_mag(longint v, longint lim);
    if (v > lim) begin
      return lim;
    end
    if (v < -lim) begin
      return -lim;
    end
    return v;
  endfunction

  function automatic longint magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Q16.16 product, floored. The second operand may be as wide as the 48-bit integral, so
  // it is split into a high part and a 16-bit low part to keep the product inside 64 bits.
  function automatic longint q_mul(longint a, longint b);
    longint lo;
    longint hi;
    lo = b & 64'hFFFF;
    hi = b >>> 16;
    return a * hi + ((a * lo) >>> 16);
  endfunction

  // Works out the output word for one sample and moves the predicted state forward.
  function automatic drive_word_t predict_drive(logic signed [31:0] ref_in,
                                                logic signed [31:0] meas_in,
                                                logic [30:0] dt_in);
    drive_word_t w;
    longint r, m, dt, err, fut, fp, fi, fd, fu, ci, d, cd, u;
    longint sig, delta, raw, filt, gd, gu;
    bit skip, hinder;
    logic [1:0] smode;
    r = longint'(ref_in);
    m = longint'(meas_in);
    dt = longint'(dt_in);
    d = 0;
    skip = 1'b0;
    if (dt == 0) begin
      dt = 1;
    end
    err = sat_word(r - m);

    fut = sat_limit(integ + q_mul(err, dt), (64'sd1 <<< 47) - 1);
    fp = sat_word(q_mul(p_gain, err));
    fi = sat_word(q_mul(i_gain, fut));
    fd = d_gain != 0 ? sat_word(q_mul(d_gain, prev_filt)) : 0;
    fu = fp + fi + fd;
    hinder = last_err_ok &&
             ((last_err < 0 && err > 0) || (last_err > 0 && err < 0)) &&
             magnitude(err) > longint'(OVERSHOOT_ERR) &&
             ((fp < 0 && fi > 0) || (fp > 0 && fi < 0)) &&
             magnitude(fi) > q_mul(longint'(DOMINANCE_RATIO), magnitude(fp));
    if (mode[0]) begin
      if ((fu > lim_hi && err > 0) || (fu < lim_lo && err < 0)) begin
        skip = 1'b1;
      end
      if (hinder) begin
        if (longint'(LEAK_FRACTION) > 0) begin
          fut = q_mul(longint'(LEAK_KEEP), integ);
        end else begin
          skip = 1'b1;
        end
      end
    end
    if (!skip) begin
      integ = fut;
    end
    integ = clamp_mag(integ, i_clamp);
    ci = sat_word(q_mul(i_gain, integ));

    // The derivative path is frozen entirely while its gain is zero.
    if (d_gain != 0) begin
      sig = mode[1] ? sat_word(-m) : err;
      if (!prev_sig_ok) begin
        prev_sig = sig;
        prev_sig_ok = 1'b1;
        prev_filt = 0;
      end else begin
        delta = sig - prev_sig;
        raw = magnitude(delta) < longint'(DERIV_DEADBAND) ? 0 : (delta * 65536) / dt;
        raw = clamp_mag(raw, d_clamp);
        if (longint'(DERIV_TAU) > 0) begin
          filt = (longint'(DERIV_TAU) * prev_filt + dt * raw) / (longint'(DERIV_TAU) + dt);
        end else begin
          filt = raw;
        end
        filt = clamp_mag(filt, d_clamp);
        smode = mode[3:2];
        if (smode == SAT_CUT || smode == SAT_BLEND) begin
          gd = sat_word(q_mul(d_gain, filt));
          gu = fp + ci + gd;
          if ((gu > lim_hi && gd > 0) || (gu < lim_lo && gd < 0)) begin
            filt = smode == SAT_CUT ? 0 : q_mul(longint'(BLEND_GAIN), filt);
          end
        end
        prev_sig = sig;
        prev_filt = filt;
        d = filt;
      end
    end
    cd = sat_word(q_mul(d_gain, d));

    u = fp + ci + cd;
    w.saturated = 1'b0;
    if (u > lim_hi) begin
      u = lim_hi;
      w.saturated = 1'b1;
    end else if (u < lim_lo) begin
      u = lim_lo;
      w.saturated = 1'b1;
    end
    w.drive = u[31:0];
    last_err = err;
    last_err_ok = 1'b1;
    return w;
  endfunction

  function automatic void clear_prediction();
    p_gain = 65536;
    i_gain = 0;
    d_gain = 0;
    lim_hi = 64'sd2147483647;
    lim_lo = -64'sd2147483648;
    i_clamp = 64'sd2147483647;
    d_clamp = 64'sd2147483647;
    mode = 4'd7;
    integ = 0;
    last_err = 0;
    prev_sig = 0;
    prev_filt = 0;
    last_err_ok = 1'b0;
    prev_sig_ok = 1'b0;
  endfunction

  // Random idling: true with a chance of 19 in a hundred, unless the no-idle stretch is on.
  function automatic bit idle_now();
    return !idle_free && ($urandom_range(99) < 19);
  endfunction

  // Drives one sample word and waits until the block accepts it. The expectation is
  // queued at the accepting edge, so it always precedes the matching output word.
  task automatic send_sample(logic signed [31:0] ref_in, logic signed [31:0] meas_in,
                             logic [30:0] dt_in);
    while (idle_now()) begin
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.reference <= ref_in;
    in_ch.measured <= meas_in;
    in_ch.step_time <= dt_in;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    expected_drives.push_back(predict_drive(ref_in, meas_in, dt_in));
    words_sent++;
    in_ch.valid <= 1'b0;
    // The block is busy with this word, so the gap costs nothing.
    @(posedge clk);
  endtask

  // Writes one control register; the block is idle whenever this is called.
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) begin
      @(posedge clk);
    end
    cfg.valid <= 1'b0;
    case (idx)
      REG_PROP_GAIN:   p_gain = longint'($signed(value));
      REG_INTEG_GAIN:  i_gain = longint'($signed(value));
      REG_DERIV_GAIN:  d_gain = longint'($signed(value));
      REG_DRIVE_MAX:   lim_hi = longint'($signed(value));
      REG_DRIVE_MIN:   lim_lo = longint'($signed(value));
      REG_INTEG_CLAMP: i_clamp = longint'(value[30:0]);
      REG_DERIV_CLAMP: d_clamp = longint'(value[30:0]);
      REG_MODE_FLAGS:  mode = value[3:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Waits until every expected word has arrived, then lets the sequencer settle.
  task automatic drain();
    while (expected_drives.size() != 0) begin
      @(posedge clk);
    end
    repeat (200) @(posedge clk);
  endtask

  task automatic write_all(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                           logic [31:0] hi, logic [31:0] lo, logic [31:0] ic,
                           logic [31:0] dc, logic [3:0] md);
    drain();
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_DERIV_GAIN, kd);
    write_reg(REG_DRIVE_MAX, hi);
    write_reg(REG_DRIVE_MIN, lo);
    write_reg(REG_INTEG_CLAMP, ic);
    write_reg(REG_DERIV_CLAMP, dc);
    write_reg(REG_MODE_FLAGS, {28'd0, md});
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(20) << 16;
      3: return -($urandom_range(20) << 16);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [30:0] rand_step();
    case ($urandom_range(4))
      0: return 31'd0;
      1: return 31'h7FFF_FFFF;
      2: return 31'd1;
      default: return 31'($urandom_range(32'h0002_0000, 32'h0000_0100));
    endcase
  endfunction

  // Extremes of every field, zero step time, sign changes of the error and
  // the first derivative sample right after enabling the path.
  task automatic test_directed();
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 31'd0);
    send_sample(32'd0, 32'd0, 31'd1);
    write_all(32'h0002_0000, 32'h0000_8000, 32'h0000_4000, 32'h0010_0000,
              32'hFFF0_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 4'd7);
    send_sample(32'h0004_0000, 32'h0000_0000, 31'h0001_0000);
    send_sample(32'h0004_0000, 32'h0008_0000, 31'h0000_8000);
    send_sample(32'hFFFC_0000, 32'h0002_0000, 31'd0);
    send_sample(32'h0006_0000, 32'h8000_0000, 31'h0000_0001);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
    send_sample(32'h0000_0000, 32'h0000_1000, 31'h0001_0000);
    // Derivative on error with cut, then on measurement with blend and with mode three treated as none.
    write_all(32'h0001_0000, 32'h0001_0000, 32'h0008_0000, 32'h0002_0000,
              32'hFFFE_0000, 32'h0010_0000, 32'h0040_0000, 4'b0101);
    send_sample(32'h0001_0000, 32'h0000_0000, 31'h0001_0000);
    send_sample(32'h0003_0000, 32'h0000_0000, 31'h0001_0000);
    send_sample(32'hFFFD_0000, 32'h0000_0000, 31'h0001_0000);
    drain();
    write_reg(REG_MODE_FLAGS, 32'd11);
    send_sample(32'h0005_0000, 32'h0000_0000, 31'h0000_4000);
    send_sample(32'hFFF0_0000, 32'h0000_0000, 31'h0000_4000);
    drain();
    write_reg(REG_MODE_FLAGS, 32'd15);
    send_sample(32'h0002_0000, 32'h0001_0000, 31'h0001_0000);
    send_sample(32'h0000_0000, 32'h0007_0000, 31'h0001_0000);
    drain();
    write_reg(REG_MODE_FLAGS, 32'd0);
    send_sample(32'h0009_0000, 32'h0000_0000, 31'h0001_0000);
    send_sample(32'hFFF7_0000, 32'h0000_0000, 31'h0001_0000);
  endtask

  // Random samples under a randomly chosen setting. Most settings use modest gains so that
  // the loop stays inside its limits part of the time; a few use the register extremes.
  task automatic test_random_phase(int count, bit extreme);
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] base;
    hi = extreme ? rand_word() : ($urandom_range(40) << 16);
    lo = extreme ? rand_word() : -($urandom_range(40) << 16);
    if (extreme) begin
      write_all(rand_word(), rand_word(), rand_word(), hi, lo, rand_word(), rand_word(),
                4'($urandom_range(11)));
    end else begin
      write_all($urandom_range(32'h0004_0000), $urandom_range(32'h0002_0000),
                $urandom_range(32'h0001_0000) - 32'h0000_8000, hi, lo,
                $urandom_range(32'h0100_0000), $urandom_range(32'h0100_0000),
                4'($urandom_range(11)));
    end
    base = $urandom_range(32'h0010_0000);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(9) < 7) begin
        // A smooth trajectory around a setpoint, which is what reaches the anti-windup
        // and saturation logic.
        send_sample(base, base + ($urandom_range(32'h0008_0000) - 32'h0004_0000),
                    31'($urandom_range(32'h0002_0000, 32'h0000_1000)));
      end else begin
        send_sample(rand_word(), rand_word(), rand_step());
      end
    end
  endtask

  // The receiver holds off for a long stretch while samples keep coming, so the block
  // fills up and stalls its input; afterwards the sender waits for every result.
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        for (int k = 0; k < 6; k++) begin
          send_sample(rand_word(), rand_word(), rand_step());
        end
      end
      begin
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
    join
    drain();
  endtask

  // Every sample without any idling on either side.
  task automatic test_no_idle();
    idle_free = 1'b1;
    for (int k = 0; k < 60; k++) begin
      send_sample(rand_word(), rand_word(), rand_step());
    end
    drain();
    idle_free = 1'b0;
  endtask

  // Output checker: each word is compared with the oldest expectation.
  always @(posedge clk) begin
    drive_word_t exp_w;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_off && !idle_now();
      if (out_ch.valid && out_ch.ready) begin
        words_checked++;
        if (expected_drives.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected output word drive=%h sat=%b", out_ch.drive, out_ch.saturated);
          end
        end else begin
          exp_w = expected_drives.pop_front();
          if (out_ch.saturated) begin
            saturated_seen++;
          end
          if (exp_w.drive !== out_ch.drive || exp_w.saturated !== out_ch.saturated) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("word %0d: expected drive=%h sat=%b, got drive=%h sat=%b",
                       words_checked, exp_w.drive, exp_w.saturated,
                       out_ch.drive, out_ch.saturated);
            end
          end
        end
      end
    end
  end

  // Watchdog, far beyond the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.reference = '0;
    in_ch.measured = '0;
    in_ch.step_time = '0;
    cfg.valid = 1'b0;
    cfg.index = REG_PROP_GAIN;
    cfg.data = '0;
    mismatches = 0;
    words_sent = 0;
    words_checked = 0;
    saturated_seen = 0;
    idle_free = 1'b0;
    hold_off = 1'b0;
    clear_prediction();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_backpressure();
    for (int ph = 0; ph < 10; ph++) begin
      test_random_phase(40, ph % 4 == 3);
    end
    test_no_idle();
    for (int ph = 0; ph < 2; ph++) begin
      test_random_phase(30, 1'b0);
    end

    drain();
    if (expected_drives.size() != 0) begin
      mismatches++;
    end
    $display("Ran %0d samples over many gain, limit and mode settings; %0d outputs checked,",
             words_sent, words_checked);
    $display("%0d of them saturated, %0d mismatches.", saturated_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
